// ===== hdl/sm83alu_pkg.sv =====
// shared types, operation codes and flag positions of the sm83 eight-bit alu
`default_nettype none

package sm83alu_pkg;

	// operation codes
	localparam logic [4:0] FUNC_ADD  = 5'd0;
	localparam logic [4:0] FUNC_ADC  = 5'd1;
	localparam logic [4:0] FUNC_SUB  = 5'd2;
	localparam logic [4:0] FUNC_SBC  = 5'd3;
	localparam logic [4:0] FUNC_AND  = 5'd4;
	localparam logic [4:0] FUNC_XOR  = 5'd5;
	localparam logic [4:0] FUNC_OR   = 5'd6;
	localparam logic [4:0] FUNC_RLC  = 5'd7;
	localparam logic [4:0] FUNC_RRC  = 5'd8;
	localparam logic [4:0] FUNC_RL   = 5'd9;
	localparam logic [4:0] FUNC_RR   = 5'd10;
	localparam logic [4:0] FUNC_SLA  = 5'd11;
	localparam logic [4:0] FUNC_SRA  = 5'd12;
	localparam logic [4:0] FUNC_SWAP = 5'd13;
	localparam logic [4:0] FUNC_SRL  = 5'd14;
	localparam logic [4:0] FUNC_BIT  = 5'd15;
	localparam logic [4:0] FUNC_RES  = 5'd16;
	localparam logic [4:0] FUNC_SET  = 5'd17;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	typedef struct packed {
		logic [4:0] func;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_index;
		logic [3:0] flags_in;
	} alu_cmd_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
	} alu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/sm83alu_stage.sv =====
// one valid/ready pipeline register stage, full throughput while downstream is ready
`default_nettype none

module sm83alu_stage #(
	parameter type data_t = logic
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   up_valid,
	output logic  up_ready,
	input  data_t up_data,
	output logic  dn_valid,
	input  wire   dn_ready,
	output data_t dn_data
);

	logic  valid_q;
	data_t data_q;

	// take a new beat when empty or when the held one leaves this cycle
	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= up_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sm83alu_exec.sv =====
// combinational datapath: arithmetic, logic, shifts, rotates and bit operations
`default_nettype none

module sm83alu_exec (
	input  sm83alu_pkg::alu_cmd_t cmd,
	output sm83alu_pkg::alu_rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] b;
	logic       cin;
	logic       k_add;
	logic       k_sub;
	logic [8:0] sum9;
	logic [8:0] diff9;
	logic [8:0] cy_add;
	logic [8:0] cy_sub;
	logic [7:0] mask;
	logic [7:0] r;
	logic [3:0] f;

	assign a    = cmd.operand_a;
	assign b    = cmd.operand_b;
	assign cin  = cmd.flags_in[sm83alu_pkg::FLAG_C];
	assign mask = 8'b1 << cmd.bit_index;

	assign k_add  = (cmd.func == sm83alu_pkg::FUNC_ADC) ? cin : 1'b0;
	assign k_sub  = (cmd.func == sm83alu_pkg::FUNC_SBC) ? cin : 1'b0;
	assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, k_add};
	assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, k_sub};
	// carry and borrow into each bit fall out of the operands xor the result
	assign cy_add = {1'b0, a} ^ {1'b0, b} ^ {8'b0, k_add} ^ sum9;
	assign cy_sub = {1'b0, a} ^ {1'b0, b} ^ {8'b0, k_sub} ^ diff9;

	always_comb begin
		r = a;
		f = cmd.flags_in;
		unique case (cmd.func)
			sm83alu_pkg::FUNC_ADD, sm83alu_pkg::FUNC_ADC: begin
				r = sum9[7:0];
				f = {(sum9[7:0] == 8'h00), 1'b0, cy_add[4], cy_add[8]};
			end
			sm83alu_pkg::FUNC_SUB, sm83alu_pkg::FUNC_SBC: begin
				r = diff9[7:0];
				f = {(diff9[7:0] == 8'h00), 1'b1, cy_sub[4], cy_sub[8]};
			end
			sm83alu_pkg::FUNC_AND: begin
				r = a & b;
				f = {(r == 8'h00), 1'b0, 1'b1, 1'b0};
			end
			sm83alu_pkg::FUNC_XOR: begin
				r = a ^ b;
				f = {(r == 8'h00), 3'b000};
			end
			sm83alu_pkg::FUNC_OR: begin
				r = a | b;
				f = {(r == 8'h00), 3'b000};
			end
			// rotates always clear z
			sm83alu_pkg::FUNC_RLC: begin
				r = {a[6:0], a[7]};
				f = {3'b000, a[7]};
			end
			sm83alu_pkg::FUNC_RRC: begin
				r = {a[0], a[7:1]};
				f = {3'b000, a[0]};
			end
			sm83alu_pkg::FUNC_RL: begin
				r = {a[6:0], cin};
				f = {3'b000, a[7]};
			end
			sm83alu_pkg::FUNC_RR: begin
				r = {cin, a[7:1]};
				f = {3'b000, a[0]};
			end
			sm83alu_pkg::FUNC_SLA: begin
				r = {a[6:0], 1'b0};
				f = {(r == 8'h00), 2'b00, a[7]};
			end
			sm83alu_pkg::FUNC_SRA: begin
				r = {a[7], a[7:1]};
				f = {(r == 8'h00), 2'b00, a[0]};
			end
			sm83alu_pkg::FUNC_SWAP: begin
				r = {a[3:0], a[7:4]};
				f = {(r == 8'h00), 3'b000};
			end
			sm83alu_pkg::FUNC_SRL: begin
				r = {1'b0, a[7:1]};
				f = {(r == 8'h00), 2'b00, a[0]};
			end
			sm83alu_pkg::FUNC_BIT: begin
				r = a;
				f = {((a & mask) == 8'h00), 1'b0, 1'b1, cin};
			end
			sm83alu_pkg::FUNC_RES: begin
				r = a & ~mask;
			end
			sm83alu_pkg::FUNC_SET: begin
				r = a | mask;
			end
			default: begin
				// unused codes pass operand and flags through
				r = a;
				f = cmd.flags_in;
			end
		endcase
	end

	assign rsp.result    = r;
	assign rsp.flags_out = f;

endmodule

`default_nettype wire

// ===== hdl/sm83_eight_bit_alu_core.sv =====
// a command beat is registered in the command stage, goes through the datapath and is registered in the response stage
// throughput: one command per cycle while responses are taken, set by the single-pass datapath between two registers
// the response register lets a new command in while a finished response waits to be taken
// reset: arst_n asynchronously empties both register stages; no other state
`default_nettype none

module sm83_eight_bit_alu_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	input  sm83alu_pkg::alu_cmd_t cmd,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output sm83alu_pkg::alu_rsp_t rsp
);

	logic                  s1_valid;
	logic                  s2_ready;
	sm83alu_pkg::alu_cmd_t s1_cmd;
	sm83alu_pkg::alu_rsp_t s1_rsp;

	sm83alu_stage #(
		.data_t(sm83alu_pkg::alu_cmd_t)
	) u_cmd_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cmd_valid),
		.up_ready (cmd_ready),
		.up_data  (cmd),
		.dn_valid (s1_valid),
		.dn_ready (s2_ready),
		.dn_data  (s1_cmd)
	);

	sm83alu_exec u_exec (
		.cmd (s1_cmd),
		.rsp (s1_rsp)
	);

	sm83alu_stage #(
		.data_t(sm83alu_pkg::alu_rsp_t)
	) u_rsp_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s2_ready),
		.up_data  (s1_rsp),
		.dn_valid (rsp_valid),
		.dn_ready (rsp_ready),
		.dn_data  (rsp)
	);

	// an accepted command lands in the first stage
	a_cmd_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> s1_valid)
		else $error("accepted command did not reach stage one");

	// a command moving on always produces a response
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s2_ready |=> rsp_valid)
		else $error("command left stage one without a response");

	// bit test returns the operand untouched
	a_bit_keeps_operand: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s2_ready && s1_cmd.func == sm83alu_pkg::FUNC_BIT
		|=> rsp.result == $past(s1_cmd.operand_a))
		else $error("bit test changed the operand");

	// res and set leave every flag alone
	a_res_set_flags: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s2_ready
		&& (s1_cmd.func == sm83alu_pkg::FUNC_RES || s1_cmd.func == sm83alu_pkg::FUNC_SET)
		|=> rsp.flags_out == $past(s1_cmd.flags_in))
		else $error("res or set altered the flags");

endmodule

`default_nettype wire
